FILE: hw/rtl/fwps_pkg.sv
// shared constants for the four-wheel period-to-speed block
package fwps_pkg;

    localparam int CFG_W   = 32;
    localparam int IDX_W   = 1;
    localparam int CHAN_W  = 2;
    localparam int CAP_W   = 16;
    localparam int SPEED_W = 16;
    localparam int CNT_W   = 8;
    localparam int LIM_W   = 8;
    localparam int DIV_W   = 32;

    localparam logic [IDX_W-1:0] REG_NUMERATOR = 1'b0;
    localparam logic [IDX_W-1:0] REG_LIMIT     = 1'b1;

    localparam logic [CFG_W-1:0] NUMERATOR_RESET = 32'd904752000;
    localparam logic [LIM_W-1:0] LIMIT_RESET     = 8'd100;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_CAPTURE = 1'b1;

    localparam logic [CNT_W-1:0]   OVF_MAX   = 8'hFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

endpackage

FILE: hw/rtl/four_wheel_period_speed_top.sv
// top level of the four-wheel period-to-speed block
//
// input channel: i_in_valid / o_in_stall carry overflow ticks (i_mode 0) and
// wheel captures (i_mode 1, i_channel, i_capture_value). a tick bumps the
// saturating overflow count; a capture forms a timestamp and a period against
// that wheel's previous stamp and queues it for the divider.
// output channel: o_out_valid / i_out_stall carry one result per kept capture:
// wheel index, speed, saturation flag and, once every wheel has updated, the
// average speed. captures at the overflow limit or on an absent wheel give none.
// the speed comes from the one-bit-per-cycle 32-step speed divider; when an
// average is formed, its reciprocal multiply is registered in S_AVG before
// the result is shown. captures queue while the divider works on an earlier
// one; ticks are taken every cycle while the two-entry queue has room.
// a stalled result holds; the queue keeps taking items until full, then
// o_in_stall rises. reset (synchronous, active low) clears counts, stamps,
// speeds and marks and loads the register defaults. registers are written
// through i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce this.
module four_wheel_period_speed_top #(
    parameter int WHEELS     = 4,
    parameter int TIMER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fwps_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [fwps_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [fwps_pkg::CHAN_W-1:0]   i_channel,
    input  logic [fwps_pkg::CAP_W-1:0]    i_capture_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fwps_pkg::CHAN_W-1:0]   o_wheel_index,
    output logic [fwps_pkg::SPEED_W-1:0]  o_wheel_speed,
    output logic                          o_speed_saturated,
    output logic                          o_average_valid,
    output logic [fwps_pkg::SPEED_W-1:0]  o_average_speed
);

    localparam int QW = fwps_pkg::CHAN_W + 8 + TIMER_BITS;

    logic [fwps_pkg::CFG_W-1:0] r_numerator;
    logic [fwps_pkg::LIM_W-1:0] r_limit;

    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator <= fwps_pkg::NUMERATOR_RESET;
            r_limit     <= fwps_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fwps_pkg::REG_NUMERATOR: r_numerator <= i_cfg_data;
                fwps_pkg::REG_LIMIT:     r_limit     <= i_cfg_data[fwps_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fwps_front #(
        .WHEELS     (WHEELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_channel       (i_channel),
        .i_capture_value (i_capture_value),
        .i_limit         (r_limit),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_data        (q_wdata)
    );

    fwps_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fwps_back #(
        .WHEELS     (WHEELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_q_data          (q_rdata),
        .o_q_pop           (q_pop),
        .i_numerator       (r_numerator),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_wheel_index     (o_wheel_index),
        .o_wheel_speed     (o_wheel_speed),
        .o_speed_saturated (o_speed_saturated),
        .o_average_valid   (o_average_valid),
        .o_average_speed   (o_average_speed)
    );

endmodule

FILE: hw/rtl/fwps_fifo.sv
// two-entry queue between the capture front and the divide back
module fwps_fifo #(
    parameter int WIDTH = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/fwps_front.sv
// front: overflow counting, capture filtering, timestamp and period
module fwps_front #(
    parameter int WHEELS     = 4,
    parameter int TIMER_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_mode,
    input  logic [fwps_pkg::CHAN_W-1:0]  i_channel,
    input  logic [fwps_pkg::CAP_W-1:0]   i_capture_value,
    input  logic [fwps_pkg::LIM_W-1:0]   i_limit,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output logic [fwps_pkg::CHAN_W+8+TIMER_BITS-1:0] o_q_data
);

    localparam int SB = 8 + TIMER_BITS;
    localparam int WL = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    logic [fwps_pkg::CNT_W-1:0] r_ovf;
    logic [SB-1:0]              r_last [WHEELS];

    logic                  accept;
    logic                  live;
    logic [WL-1:0]         idx;
    logic [TIMER_BITS-1:0] cap_v;
    logic [SB-1:0]         stamp;
    logic [SB-1:0]         period;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid & ~i_q_full;
    assign idx        = WL'(i_channel);
    assign cap_v      = TIMER_BITS'(i_capture_value);
    assign stamp      = {r_ovf, cap_v};
    assign period     = stamp - r_last[idx];
    // captures count only while the overflow count is below the limit and the channel names a present wheel
    assign live       = (r_ovf < i_limit) && (int'(i_channel) < WHEELS);

    assign o_q_push = accept && (i_mode == fwps_pkg::MODE_CAPTURE) && live;
    assign o_q_data = {i_channel, period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= '0;
            for (int w = 0; w < WHEELS; w++) begin
                r_last[w] <= '0;
            end
        end else begin
            if (accept && (i_mode == fwps_pkg::MODE_TICK) && (r_ovf != fwps_pkg::OVF_MAX)) begin
                r_ovf <= r_ovf + 8'd1;
            end
            if (o_q_push) begin
                r_last[idx] <= stamp;
            end
        end
    end

endmodule

FILE: hw/rtl/fwps_div.sv
// restoring divider, one quotient bit per cycle
module fwps_div #(
    parameter int DVS_W = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fwps_pkg::DIV_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]            i_divisor,
    output logic                        o_done,
    output logic [fwps_pkg::DIV_W-1:0]  o_quotient
);

    localparam int DW  = fwps_pkg::DIV_W;
    localparam int CW  = $clog2(DW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    trial;
    logic              ge;

    assign trial      = {r_rem, r_q[DW-1]};
    assign ge         = trial >= {1'b0, r_dvs};
    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], ge};
            r_rem <= ge ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/fwps_back.sv
// back: speed division, per-wheel store, average and result register
module fwps_back #(
    parameter int WHEELS     = 4,
    parameter int TIMER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  logic [fwps_pkg::CHAN_W+8+TIMER_BITS-1:0] i_q_data,
    output logic                          o_q_pop,
    input  logic [fwps_pkg::CFG_W-1:0]    i_numerator,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fwps_pkg::CHAN_W-1:0]   o_wheel_index,
    output logic [fwps_pkg::SPEED_W-1:0]  o_wheel_speed,
    output logic                          o_speed_saturated,
    output logic                          o_average_valid,
    output logic [fwps_pkg::SPEED_W-1:0]  o_average_speed
);

    localparam int SB   = 8 + TIMER_BITS;
    localparam int WL   = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam int SUMW = fwps_pkg::SPEED_W + $clog2(WHEELS);
    localparam int SPW  = fwps_pkg::SPEED_W;
    localparam int DW   = fwps_pkg::DIV_W;
    localparam int RL   = $clog2(WHEELS);
    localparam int RW   = SUMW + 1;
    localparam int PW   = 2 * SUMW + 1;
    // reciprocal of the wheel count, exact floor for every reachable total
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << (SUMW + RL)) + 64'(WHEELS) - 64'd1) / 64'(WHEELS));

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SPEED = 2'd1;
    localparam logic [1:0] S_AVG   = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]        r_state;
    logic [SPW-1:0]    r_store [WHEELS];
    logic [WHEELS-1:0] r_marks;
    logic [SUMW-1:0]   r_sum;
    logic              r_zero;

    logic [fwps_pkg::CHAN_W-1:0] r_chan;
    logic [SPW-1:0]              r_speed;
    logic                        r_sat;
    logic                        r_avg_valid;
    logic [SPW-1:0]              r_avg;

    logic                         div_start;
    logic [DW-1:0]                div_dividend;
    logic [SB-1:0]                div_divisor;
    logic                         div_done;
    logic [DW-1:0]                div_q;

    logic [fwps_pkg::CHAN_W-1:0]  q_chan;
    logic [SB-1:0]                q_period;
    logic [WL-1:0]                idx;
    logic                         sat;
    logic [SPW-1:0]               speed;
    logic [SUMW-1:0]              sum_next;
    logic [WHEELS-1:0]            marks_set;
    logic                         all_set;
    logic [PW-1:0]                avg_prod;
    logic [SPW-1:0]               avg_q;

    assign q_chan   = i_q_data[SB +: fwps_pkg::CHAN_W];
    assign q_period = i_q_data[SB-1:0];
    assign idx      = WL'(r_chan);

    assign sat       = r_zero || (div_q[DW-1:SPW] != '0);
    assign speed     = sat ? fwps_pkg::SPEED_MAX : div_q[SPW-1:0];
    // running total follows every store update
    assign sum_next  = r_sum - SUMW'(r_store[idx]) + SUMW'(speed);
    assign marks_set = r_marks | (WHEELS'(1) << idx);
    assign all_set   = &marks_set;

    assign avg_prod = PW'(r_sum) * PW'(RECIP);
    assign avg_q    = avg_prod[SUMW+RL +: SPW];

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    assign div_start    = o_q_pop;
    assign div_dividend = i_numerator;
    assign div_divisor  = q_period;

    fwps_div #(
        .DVS_W (SB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_out_valid       = (r_state == S_OUT);
    assign o_wheel_index     = r_chan;
    assign o_wheel_speed     = r_speed;
    assign o_speed_saturated = r_sat;
    assign o_average_valid   = r_avg_valid;
    assign o_average_speed   = r_avg;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    r_chan <= q_chan;
                    r_zero <= (q_period == '0);
                end
            end
            S_SPEED: begin
                if (div_done) begin
                    r_speed     <= speed;
                    r_sat       <= sat;
                    r_avg_valid <= all_set;
                    r_avg       <= '0;
                end
            end
            S_AVG: begin
                r_avg <= avg_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_marks <= '0;
            r_sum   <= '0;
            for (int w = 0; w < WHEELS; w++) begin
                r_store[w] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_SPEED;
                    end
                end
                S_SPEED: begin
                    if (div_done) begin
                        r_store[idx] <= speed;
                        r_sum        <= sum_next;
                        if (all_set) begin
                            r_marks <= '0;
                            r_state <= S_AVG;
                        end else begin
                            r_marks <= marks_set;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_AVG: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
